// ===== hdl/tsa_pkg.sv =====
`timescale 1ns / 1ps

package tsa_pkg;

    localparam int NUM_SLOTS       = 8;
    localparam int THREAD_ID_WIDTH = 16;

    localparam int IN_TID_W = 16;
    localparam int TID_W    = THREAD_ID_WIDTH;
    localparam int SLOT_W   = (NUM_SLOTS > 1) ? $clog2(NUM_SLOTS) : 1;
    localparam int COUNT_W  = $clog2(NUM_SLOTS + 1);
    localparam int SUM_W    = COUNT_W + 1;

    localparam int IN_DATA_W  = 24;
    localparam int OUT_DATA_W = 8;

    localparam logic [1:0] OP_RESERVE = 2'd0;
    localparam logic [1:0] OP_FREE    = 2'd1;
    localparam logic [1:0] OP_LOOKUP  = 2'd2;

    typedef enum logic [1:0] {
        ST_OK            = 2'd0,
        ST_NOT_BOUND     = 2'd1,
        ST_ALREADY_BOUND = 2'd2,
        ST_NO_FREE       = 2'd3
    } t_status;

    typedef struct packed {
        logic exec;
    } t_dp_cmd;

    function automatic logic [TID_W-1:0] tid_of(input logic [IN_TID_W-1:0] v);
        logic [TID_W+IN_TID_W-1:0] ext;
        ext = {{TID_W{1'b0}}, v};
        return ext[TID_W-1:0];
    endfunction

endpackage

// ===== hdl/tsa_ctrl.sv =====
`timescale 1ns / 1ps

module tsa_ctrl
    import tsa_pkg::*;
(
    input  logic    i_clk,
    input  logic    i_rst_n,
    input  logic    i_in_valid,
    output logic    o_in_ready,
    output logic    o_out_valid,
    input  logic    i_out_ready,
    output t_dp_cmd o_cmd
);

    typedef enum logic {
        S_EMPTY,
        S_FULL
    } t_state;

    t_state r_state;
    t_state n_state;
    logic   w_accept;

    assign o_in_ready  = (r_state == S_EMPTY) || i_out_ready;
    assign w_accept    = i_in_valid && o_in_ready;
    assign o_out_valid = (r_state == S_FULL);
    assign o_cmd.exec  = w_accept;

    always_comb begin
        case (r_state)
            S_EMPTY: begin
                n_state = w_accept ? S_FULL : S_EMPTY;
            end
            S_FULL: begin
                if (w_accept) begin
                    n_state = S_FULL;
                end else if (i_out_ready) begin
                    n_state = S_EMPTY;
                end else begin
                    n_state = S_FULL;
                end
            end
            default: begin
                n_state = S_EMPTY;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_EMPTY;
        end else begin
            r_state <= n_state;
        end
    end

`ifndef SYNTHESIS
    a_accept_gives_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_accept |=> o_out_valid)
        else $error("Accepted item did not produce a result.");
`endif

endmodule

// ===== hdl/tsa_datapath.sv =====
`timescale 1ns / 1ps

module tsa_datapath
    import tsa_pkg::*;
(
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  t_dp_cmd             i_cmd,
    input  logic [1:0]          i_op,
    input  logic [IN_TID_W-1:0] i_tid,
    output logic [2:0]          o_slot_index,
    output logic                o_found,
    output logic [1:0]          o_status
);

    logic [SLOT_W-1:0]  r_free_fifo [NUM_SLOTS];
    logic [SLOT_W-1:0]  r_free_head;
    logic [COUNT_W-1:0] r_free_count;
    logic [TID_W-1:0]   r_slot_owner [NUM_SLOTS];
    logic [NUM_SLOTS-1:0] r_slot_bound;

    logic [2:0] r_slot_index;
    logic       r_found;
    t_status    r_status;

    logic [TID_W-1:0]    w_tid;
    logic                w_hit;
    logic [SLOT_W-1:0]   w_hit_idx;
    logic [SLOT_W-1:0]   w_head_slot;
    logic [SLOT_W-1:0]   w_head_next;
    logic [SUM_W-1:0]    w_tail_sum;
    logic [SLOT_W-1:0]   w_tail;
    logic                w_is_reserve;
    logic                w_is_free;
    logic                w_do_reserve;
    logic                w_do_push;
    logic                w_do_unbind;
    t_status             w_status;
    logic [SLOT_W-1:0]   w_slot;
    logic [SLOT_W+2:0]   w_slot_ext;

    assign w_tid = tid_of(i_tid);

    always_comb begin
        w_hit     = 1'b0;
        w_hit_idx = '0;
        for (int i = 0; i < NUM_SLOTS; i++) begin
            if (!w_hit && r_slot_bound[i] && (r_slot_owner[i] == w_tid)) begin
                w_hit     = 1'b1;
                w_hit_idx = SLOT_W'(i);
            end
        end
    end

    assign w_head_slot = r_free_fifo[r_free_head];
    assign w_head_next = (r_free_head == SLOT_W'(NUM_SLOTS - 1)) ? '0
                                                                 : r_free_head + 1'b1;
    assign w_tail_sum  = SUM_W'(r_free_head) + SUM_W'(r_free_count);
    assign w_tail      = (w_tail_sum >= SUM_W'(NUM_SLOTS))
                       ? SLOT_W'(w_tail_sum - SUM_W'(NUM_SLOTS))
                       : SLOT_W'(w_tail_sum);

    assign w_is_reserve = (i_op == OP_RESERVE);
    assign w_is_free    = (i_op == OP_FREE);

    always_comb begin
        w_do_reserve = 1'b0;
        w_do_push    = 1'b0;
        w_do_unbind  = 1'b0;
        w_status     = ST_OK;
        w_slot       = '0;
        if (w_is_reserve) begin
            if (w_hit) begin
                w_status = ST_ALREADY_BOUND;
            end else if (r_free_count == '0) begin
                w_status = ST_NO_FREE;
            end else begin
                w_do_reserve = 1'b1;
                w_slot       = w_head_slot;
            end
        end else if (w_is_free) begin
            if (!w_hit) begin
                w_status = ST_NOT_BOUND;
            end else begin
                w_do_unbind = 1'b1;
                w_do_push   = (r_free_count < COUNT_W'(NUM_SLOTS));
                w_slot      = w_hit_idx;
            end
        end else begin
            if (!w_hit) begin
                w_status = ST_NOT_BOUND;
            end else begin
                w_slot = w_hit_idx;
            end
        end
    end

    assign w_slot_ext = {3'b000, w_slot};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int i = 0; i < NUM_SLOTS; i++) begin
                r_free_fifo[i] <= SLOT_W'(i);
            end
            r_free_head  <= '0;
            r_free_count <= COUNT_W'(NUM_SLOTS);
            r_slot_bound <= '0;
        end else if (i_cmd.exec) begin
            if (w_do_reserve) begin
                r_free_head               <= w_head_next;
                r_free_count              <= r_free_count - 1'b1;
                r_slot_bound[w_head_slot] <= 1'b1;
            end
            if (w_do_push) begin
                r_free_fifo[w_tail] <= w_hit_idx;
                r_free_count        <= r_free_count + 1'b1;
            end
            if (w_do_unbind) begin
                r_slot_bound[w_hit_idx] <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.exec) begin
            if (w_do_reserve) begin
                r_slot_owner[w_head_slot] <= w_tid;
            end
            r_slot_index <= w_slot_ext[2:0];
            r_found      <= w_hit;
            r_status     <= w_status;
        end
    end

    assign o_slot_index = r_slot_index;
    assign o_found      = r_found;
    assign o_status     = r_status;

`ifndef SYNTHESIS
    a_slots_conserved: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        ($countones(r_slot_bound) + int'(r_free_count)) == NUM_SLOTS)
        else $error("Free count and bound slots do not add up to the pool size.");

    a_count_in_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_free_count <= COUNT_W'(NUM_SLOTS))
        else $error("Free count exceeds the pool size.");

    a_reserve_pops: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_cmd.exec && w_do_reserve) |=>
            (r_free_count == $past(r_free_count) - 1'b1) && r_slot_bound[$past(w_head_slot)])
        else $error("Successful reserve did not take a slot from the free list.");
`endif

endmodule

// ===== hdl/thread_slot_allocator_core.sv =====
// A result appears in the output register in the cycle after its item is accepted.
// Throughput: one item per cycle unless the output stalls; the lookup is a parallel
// compare over all slot owners and the free list moves its head or tail pointer by one
// entry in the same cycle. A new item is accepted whenever the output register is empty
// or is being taken. Reset is synchronous and active low; it marks every slot unbound and
// refills the free list with slots 0 to NUM_SLOTS-1 in order, with no clearing pass.
`timescale 1ns / 1ps

module thread_slot_allocator_core
    import tsa_pkg::*;
(
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_s_axis_tvalid,
    output logic                  o_s_axis_tready,
    input  logic [IN_DATA_W-1:0]  i_s_axis_tdata,  // op[1:0], tid[17:2], zero pad
    output logic                  o_m_axis_tvalid,
    input  logic                  i_m_axis_tready,
    output logic [OUT_DATA_W-1:0] o_m_axis_tdata   // slot_index[2:0], found[3], status[5:4]
);

    t_dp_cmd    w_cmd;
    logic [2:0] w_slot_index;
    logic       w_found;
    logic [1:0] w_status;

    tsa_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_s_axis_tvalid),
        .o_in_ready  (o_s_axis_tready),
        .o_out_valid (o_m_axis_tvalid),
        .i_out_ready (i_m_axis_tready),
        .o_cmd       (w_cmd)
    );

    tsa_datapath u_datapath (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cmd        (w_cmd),
        .i_op         (i_s_axis_tdata[1:0]),
        .i_tid        (i_s_axis_tdata[17:2]),
        .o_slot_index (w_slot_index),
        .o_found      (w_found),
        .o_status     (w_status)
    );

    assign o_m_axis_tdata = {2'b00, w_status, w_found, w_slot_index};

endmodule
